FILE: rtl/pnc_pkg.sv
package pnc_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_WRITE  = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_FIND   = 2'd2;

  localparam int CH_W   = 8;
  localparam int IDX_W  = 5;
  localparam int BIDX_W = 4;
  localparam int DIST_W = 18;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 56;

  // Red sits in the lowest byte, alpha in the highest.
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgba_t;

  localparam rgba_t BACKGROUND = '{alpha: 8'd255, blue: 8'd0, green: 8'd0, red: 8'd0};

  function automatic rgba_t opaque(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b);
    rgba_t c;
    c = '{alpha: 8'd255, blue: b, green: g, red: r};
    return c;
  endfunction

  // Power-on palette; entries past the sixteenth come up as all zero.
  function automatic rgba_t default_color(input logic [7:0] a);
    rgba_t c;
    case (a)
      8'd0:    c = opaque(8'd0,   8'd0,   8'd0);
      8'd1:    c = opaque(8'd224, 8'd224, 8'd224);
      8'd2:    c = opaque(8'd192, 8'd192, 8'd192);
      8'd3:    c = opaque(8'd160, 8'd160, 8'd160);
      8'd4:    c = opaque(8'd96,  8'd96,  8'd96);
      8'd5:    c = opaque(8'd32,  8'd32,  8'd32);
      8'd6:    c = opaque(8'd0,   8'd0,   8'd100);
      8'd7:    c = opaque(8'd0,   8'd0,   8'd255);
      8'd8:    c = opaque(8'd255, 8'd0,   8'd0);
      8'd9:    c = opaque(8'd0,   8'd0,   8'd200);
      8'd10:   c = opaque(8'd0,   8'd200, 8'd0);
      8'd11:   c = opaque(8'd200, 8'd0,   8'd0);
      8'd12:   c = opaque(8'd0,   8'd255, 8'd255);
      8'd13:   c = opaque(8'd255, 8'd255, 8'd0);
      8'd14:   c = opaque(8'd255, 8'd0,   8'd255);
      8'd15:   c = opaque(8'd255, 8'd255, 8'd255);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/palette_nearest_color.sv
// Write: no result beat. Lookup: the entry is read on acceptance, then captured in the result
// register and loaded into the output register; the next beat is taken after that load. Find:
// one palette entry is read from the single-port palette memory and scored per cycle, and the
// next beat is taken only after the result has been loaded (later while out_tready stalls).
// rst_n (synchronous, active low) clears the control state and the per-entry valid bits,
// so every entry reads as its power-on palette colour until written.
module palette_nearest_color #(
  parameter int PALETTE_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // operation[1:0], entry_index[6:2], red[14:7], green[22:15], blue[30:23], alpha[38:31]
  input  logic [pnc_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24],
  // best_index[35:32], best_distance[53:36]
  output logic [pnc_pkg::OUT_W-1:0]  out_tdata
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CW = (AW + 1 > pnc_pkg::IDX_W) ? AW + 1 : pnc_pkg::IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // ---------------------------------------------------------------- input beat
  pnc_pkg::op_t                 in_op;
  logic [pnc_pkg::IDX_W-1:0]    in_idx;
  pnc_pkg::rgba_t               in_color;
  logic [CW-1:0]                idx_ext;
  logic                         idx_ok;
  logic [AW-1:0]                in_addr;
  logic                         in_acc;

  assign in_op    = in_tdata[1:0];
  assign in_idx   = in_tdata[6:2];
  assign in_color = in_tdata[38:7];
  assign idx_ext  = CW'(in_idx);
  assign idx_ok   = idx_ext < CW'(PALETTE_ENTRIES);
  assign in_addr  = idx_ext[AW-1:0];
  assign in_acc   = in_tvalid && in_tready;

  // ---------------------------------------------------------------- sequencer state
  logic [1:0]                   state_r, state_nxt;
  logic [AW:0]                  cnt_r;
  logic                         issue;
  logic                         in_range_r;
  pnc_pkg::rgba_t               key_r;

  assign in_tready = (state_r == S_IDLE);
  assign issue     = (state_r == S_SCAN) && (cnt_r < (AW + 1)'(PALETTE_ENTRIES));

  // ---------------------------------------------------------------- palette memory
  pnc_pkg::rgba_t               mem_r [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0]   vld_r;
  logic                         mem_we;
  logic [AW-1:0]                rd_addr;
  pnc_pkg::rgba_t               rdata_r;
  pnc_pkg::rgba_t               rdflt_r;
  logic                         rvld_r;
  pnc_pkg::rgba_t               entry;

  assign mem_we = in_acc && (in_op == pnc_pkg::OP_WRITE) && idx_ok;

  // Address the requested entry on acceptance, then walk the counter while scanning.
  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (in_op == pnc_pkg::OP_FIND) ? '0 : in_addr;
    end else begin
      rd_addr = cnt_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[in_addr] <= in_color;
    end
    rdata_r <= mem_r[rd_addr];
    rdflt_r <= pnc_pkg::default_color(8'(rd_addr));
    rvld_r  <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[in_addr] <= 1'b1;
    end
  end

  // An entry never written reads as its power-on colour.
  assign entry = rvld_r ? rdata_r : rdflt_r;

  // ---------------------------------------------------------------- shared distance unit
  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {8'd0, d} * {8'd0, d};
  endfunction

  logic [pnc_pkg::DIST_W-1:0]   dist_c;

  assign dist_c = 18'(sq_diff(key_r.red,   entry.red))
                + 18'(sq_diff(key_r.green, entry.green))
                + 18'(sq_diff(key_r.blue,  entry.blue))
                + 18'(sq_diff(key_r.alpha, entry.alpha));

  // Scan pipeline: read stage (rv), distance stage (dv), then compare.
  logic                         rv_r;
  logic [AW-1:0]                ridx_r;
  logic                         dv_r;
  logic [AW-1:0]                didx_r;
  logic [pnc_pkg::DIST_W-1:0]   dist_r;

  // ---------------------------------------------------------------- running minimum
  logic [AW-1:0]                best_idx_r;
  logic [pnc_pkg::DIST_W-1:0]   best_dist_r;
  logic                         take;
  logic                         last;
  logic [AW-1:0]                best_idx_nxt;
  logic [pnc_pkg::DIST_W-1:0]   best_dist_nxt;

  // Strict less-than keeps the lowest index on a tie; entry zero always seeds the minimum.
  assign take          = dv_r && ((didx_r == '0) || (dist_r < best_dist_r));
  assign last          = dv_r && (didx_r == AW'(PALETTE_ENTRIES - 1));
  assign best_idx_nxt  = take ? didx_r : best_idx_r;
  assign best_dist_nxt = take ? dist_r : best_dist_r;

  // ---------------------------------------------------------------- result and output register
  pnc_pkg::rgba_t               res_color_r;
  logic [pnc_pkg::BIDX_W-1:0]   res_idx_r;
  logic [pnc_pkg::DIST_W-1:0]   res_dist_r;
  logic                         out_free;
  logic                         out_load;
  logic                         out_valid_r;
  logic [pnc_pkg::OUT_W-1:0]    out_data_r;

  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == S_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_op == pnc_pkg::OP_LOOKUP)) begin
          state_nxt = S_LOOK;
        end else if (in_acc && (in_op == pnc_pkg::OP_FIND)) begin
          state_nxt = S_SCAN;
        end
      end
      S_LOOK: state_nxt = S_FIN;
      S_SCAN: begin
        if (last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rv_r        <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= (in_acc && (in_op == pnc_pkg::OP_FIND)) || issue;
      dv_r    <= rv_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold the key, advance the scan counter, capture results.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r      <= in_color;
      in_range_r <= idx_ok;
      cnt_r      <= (AW + 1)'(1);
      ridx_r     <= '0;
    end else if (issue) begin
      cnt_r  <= cnt_r + (AW + 1)'(1);
      ridx_r <= cnt_r[AW-1:0];
    end
    didx_r      <= ridx_r;
    dist_r      <= dist_c;
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;

    if (state_r == S_LOOK) begin
      res_color_r <= in_range_r ? entry : pnc_pkg::BACKGROUND;
      res_idx_r   <= '0;
      res_dist_r  <= '0;
    end else if ((state_r == S_SCAN) && last) begin
      res_color_r <= '0;
      res_idx_r   <= pnc_pkg::BIDX_W'(best_idx_nxt);
      res_dist_r  <= best_dist_nxt;
    end

    if (out_load) begin
      out_data_r <= {2'b00, res_dist_r, res_idx_r, res_color_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // The scan pipeline drains before the next beat can be taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!rv_r && !dv_r))
    else $error("scan pipeline busy while accepting a beat");

  // Scored entries only appear while scanning.
  a_score_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == S_SCAN))
    else $error("distance stage active outside a scan");

  // A find result never carries a distance beyond four full-scale channels.
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[53:36] <= 18'd260100))
    else $error("nearest distance out of range");

  // A result with a nonzero distance is a find result with zero colour channels.
  a_find_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[53:36] != '0)) |-> (out_tdata[31:0] == '0))
    else $error("find result carries colour data");
`endif

endmodule

FILE: tb/palette_nearest_color_tb.sv
module palette_nearest_color_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int           ENTRIES       = 16;
  localparam pnc_pkg::op_t OP_UNUSED     = 2'd3;   // the fourth code: no effect, no result
  localparam int           STALL_LIMIT   = 5000;   // cycles with no beat on either side
  localparam int           SETTLE_CYCLES = 40;
  localparam int           PHASE_ITEMS   = 407;

  // One request as the block sees it on the input stream.
  typedef struct {
    pnc_pkg::op_t   op;
    logic [4:0]     index;
    pnc_pkg::rgba_t colour;
  } request_t;

  // One result beat, unpacked into its fields.
  typedef struct {
    pnc_pkg::rgba_t colour;
    logic [3:0]     best_index;
    logic [17:0]    best_distance;
  } reply_t;

  // Mirror of the palette: applies each accepted request and keeps the replies it owes.
  class palette_mirror;
    pnc_pkg::rgba_t colours [ENTRIES];
    reply_t         pending_replies [$];
    int unsigned    mismatches;

    function new();
      reset_palette();
      mismatches = 0;
    endfunction

    function void reset_palette();
      colours[0]  = '{alpha: 8'd255, blue: 8'd0,   green: 8'd0,   red: 8'd0};
      colours[1]  = '{alpha: 8'd255, blue: 8'd224, green: 8'd224, red: 8'd224};
      colours[2]  = '{alpha: 8'd255, blue: 8'd192, green: 8'd192, red: 8'd192};
      colours[3]  = '{alpha: 8'd255, blue: 8'd160, green: 8'd160, red: 8'd160};
      colours[4]  = '{alpha: 8'd255, blue: 8'd96,  green: 8'd96,  red: 8'd96};
      colours[5]  = '{alpha: 8'd255, blue: 8'd32,  green: 8'd32,  red: 8'd32};
      colours[6]  = '{alpha: 8'd255, blue: 8'd100, green: 8'd0,   red: 8'd0};
      colours[7]  = '{alpha: 8'd255, blue: 8'd255, green: 8'd0,   red: 8'd0};
      colours[8]  = '{alpha: 8'd255, blue: 8'd0,   green: 8'd0,   red: 8'd255};
      colours[9]  = '{alpha: 8'd255, blue: 8'd200, green: 8'd0,   red: 8'd0};
      colours[10] = '{alpha: 8'd255, blue: 8'd0,   green: 8'd200, red: 8'd0};
      colours[11] = '{alpha: 8'd255, blue: 8'd0,   green: 8'd0,   red: 8'd200};
      colours[12] = '{alpha: 8'd255, blue: 8'd255, green: 8'd255, red: 8'd0};
      colours[13] = '{alpha: 8'd255, blue: 8'd0,   green: 8'd255, red: 8'd255};
      colours[14] = '{alpha: 8'd255, blue: 8'd255, green: 8'd0,   red: 8'd255};
      colours[15] = '{alpha: 8'd255, blue: 8'd255, green: 8'd255, red: 8'd255};
    endfunction

    function int unsigned channel_dist(logic [7:0] a, logic [7:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
    endfunction

    function void note_request(logic [pnc_pkg::IN_W-1:0] beat);
      pnc_pkg::op_t   op;
      logic [4:0]     index;
      pnc_pkg::rgba_t colour;
      reply_t         rep;
      int unsigned    d;
      int unsigned    best_d;
      int             best;
      op     = beat[1:0];
      index  = beat[6:2];
      colour = beat[38:7];
      rep    = '{colour: '0, best_index: '0, best_distance: '0};
      case (op)
        pnc_pkg::OP_WRITE: begin
          if (index < ENTRIES) colours[index] = colour;
        end
        pnc_pkg::OP_LOOKUP: begin
          rep.colour = (index < ENTRIES) ? colours[index] : pnc_pkg::BACKGROUND;
          pending_replies.push_back(rep);
        end
        pnc_pkg::OP_FIND: begin
          best   = 0;
          best_d = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            d = channel_dist(colour.red,   colours[i].red)
              + channel_dist(colour.green, colours[i].green)
              + channel_dist(colour.blue,  colours[i].blue)
              + channel_dist(colour.alpha, colours[i].alpha);
            if (i == 0 || d < best_d) begin
              best_d = d;
              best   = i;
            end
          end
          rep.best_index    = best[3:0];
          rep.best_distance = best_d[17:0];
          pending_replies.push_back(rep);
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_reply(logic [pnc_pkg::OUT_W-1:0] beat);
      reply_t         want;
      pnc_pkg::rgba_t got;
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result beat, expected none, actual 0x%h", $time, beat);
        return;
      end
      want = pending_replies.pop_front();
      got  = beat[31:0];
      compare("red",           want.colour.red,     got.red);
      compare("green",         want.colour.green,   got.green);
      compare("blue",          want.colour.blue,    got.blue);
      compare("alpha",         want.colour.alpha,   got.alpha);
      compare("best_index",    want.best_index,     beat[35:32]);
      compare("best_distance", want.best_distance,  beat[53:36]);
    endfunction

    function int unsigned outstanding();
      return pending_replies.size();
    endfunction
  endclass

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [pnc_pkg::IN_W-1:0]  in_tdata   = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [pnc_pkg::OUT_W-1:0] out_tdata;

  palette_mirror mirror = new();

  // Sender idle and receiver stall rates in percent, changed per phase by the stimulus; idle_cycles feeds the watchdog.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int idle_cycles   = 0;

  palette_nearest_color #(.PALETTE_ENTRIES(ENTRIES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: one fresh decision per cycle, a single assignment per edge.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor and watchdog. Check the result beat before noting the input beat: a result
  // on this edge always belongs to an earlier request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) mirror.check_reply(out_tdata);
      if (in_tvalid && in_tready) mirror.note_request(in_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic request_t make_request(pnc_pkg::op_t op, logic [4:0] index,
                                            logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b, logic [7:0] a);
    request_t req;
    req.op     = op;
    req.index  = index;
    req.colour = '{alpha: a, blue: b, green: g, red: r};
    return req;
  endfunction

  // Pick colours that land on, near or far from the current palette so that ties and
  // zero distances turn up as well as arbitrary ones.
  function automatic pnc_pkg::rgba_t random_colour();
    pnc_pkg::rgba_t c;
    int             pick;
    int             mode;
    int             v;
    mode = $urandom_range(99);
    pick = $urandom_range(ENTRIES - 1);
    c    = $urandom;
    if (mode < 20) begin
      c = mirror.colours[pick];
    end else if (mode < 45) begin
      c = mirror.colours[pick];
      for (int k = 0; k < 4; k++) begin
        v = int'(c[8*k +: 8]) + $urandom_range(8) - 4;
        c[8*k +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
      end
    end else if (mode < 55) begin
      for (int k = 0; k < 4; k++) c[8*k +: 8] = $urandom_range(1) ? 8'd255 : 8'd0;
    end
    return c;
  endfunction

  function automatic request_t random_request();
    request_t req;
    int       roll;
    roll = $urandom_range(99);
    if (roll < 38)      req.op = pnc_pkg::OP_FIND;
    else if (roll < 68) req.op = pnc_pkg::OP_LOOKUP;
    else if (roll < 96) req.op = pnc_pkg::OP_WRITE;
    else                req.op = OP_UNUSED;
    roll = $urandom_range(99);
    if (roll < 85)      req.index = 5'($urandom_range(ENTRIES - 1));
    else if (roll < 95) req.index = 5'(ENTRIES);
    else                req.index = 5'($urandom_range(31, ENTRIES + 1));
    req.colour = random_colour();
    return req;
  endfunction

  // Present one beat; hold it until the handshake edge. Sample tready at the falling edge,
  // where it is settled for the coming rising edge.
  task automatic send_request(input request_t req);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, req.colour, req.index, req.op};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) send_request(random_request());
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: power-on colours at both ends, background and out-of-range lookups.
    send_request(make_request(pnc_pkg::OP_LOOKUP, 5'd0,  8'h00, 8'h00, 8'h00, 8'h00));
    send_request(make_request(pnc_pkg::OP_LOOKUP, 5'd15, 8'hff, 8'hff, 8'hff, 8'hff));
    send_request(make_request(pnc_pkg::OP_LOOKUP, 5'd16, 8'h00, 8'h00, 8'h00, 8'h00));
    send_request(make_request(pnc_pkg::OP_LOOKUP, 5'd31, 8'hff, 8'hff, 8'hff, 8'hff));
    send_request(make_request(pnc_pkg::OP_LOOKUP, 5'd17, 8'h12, 8'h34, 8'h56, 8'h78));
    // Finds against the default palette, channel extremes and a transparent colour.
    send_request(make_request(pnc_pkg::OP_FIND,   5'd0,  8'h00, 8'h00, 8'h00, 8'h00));
    send_request(make_request(pnc_pkg::OP_FIND,   5'd31, 8'hff, 8'hff, 8'hff, 8'hff));
    send_request(make_request(pnc_pkg::OP_FIND,   5'd16, 8'd128, 8'd128, 8'd128, 8'd255));
    send_request(make_request(pnc_pkg::OP_FIND,   5'd7,  8'hff, 8'h00, 8'hff, 8'h00));
    // Writes past the end are dropped; the background still reads opaque black.
    send_request(make_request(pnc_pkg::OP_WRITE,  5'd16, 8'h11, 8'h22, 8'h33, 8'h44));
    send_request(make_request(pnc_pkg::OP_WRITE,  5'd31, 8'h55, 8'h66, 8'h77, 8'h88));
    send_request(make_request(pnc_pkg::OP_LOOKUP, 5'd16, 8'h00, 8'h00, 8'h00, 8'h00));
    // The unused code must neither answer nor touch the palette.
    send_request(make_request(OP_UNUSED,          5'd5,  8'hff, 8'hff, 8'hff, 8'hff));
    send_request(make_request(pnc_pkg::OP_LOOKUP, 5'd5,  8'h00, 8'h00, 8'h00, 8'h00));
    // Copy entry nine into twelve: an exact match then ties, and the lower index wins.
    send_request(make_request(pnc_pkg::OP_WRITE,  5'd12, 8'd0,  8'd0,  8'd200, 8'd255));
    send_request(make_request(pnc_pkg::OP_FIND,   5'd12, 8'd0,  8'd0,  8'd200, 8'd255));
    // Blue 227 lies nearer blue 200 than blue 255; of the two blue 200 entries the lower index wins.
    send_request(make_request(pnc_pkg::OP_WRITE,  5'd0,  8'd0,  8'd0,  8'd255, 8'd255));
    send_request(make_request(pnc_pkg::OP_FIND,   5'd3,  8'd0,  8'd0,  8'd227, 8'd255));
    // Overwrite the last entry with full extremes and read it back.
    send_request(make_request(pnc_pkg::OP_WRITE,  5'd15, 8'hff, 8'h00, 8'hff, 8'h00));
    send_request(make_request(pnc_pkg::OP_LOOKUP, 5'd15, 8'h00, 8'h00, 8'h00, 8'h00));
    send_request(make_request(pnc_pkg::OP_FIND,   5'd0,  8'hff, 8'h00, 8'hff, 8'h00));
    send_request(make_request(pnc_pkg::OP_LOOKUP, 5'd0,  8'h00, 8'h00, 8'h00, 8'h00));
    drain();

    // Random phases: back to back, sender gaps, receiver stalls, then light gaps on both.
    run_phase(0,  0,  PHASE_ITEMS);
    run_phase(82, 0,  PHASE_ITEMS);
    run_phase(0,  82, PHASE_ITEMS);
    run_phase(16, 16, PHASE_ITEMS);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (mirror.outstanding() != 0)
        $display("%0t ns: results never delivered, expected %0d, actual 0", $time,
                 mirror.outstanding());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
